/* hw/rtl/qspr_pkg.sv */
// Shared types and constants of the quadrature speed PI regulator.
// Holds the item structs, register indexes, reset values and the x4 edge decode.
// Depends on nothing.
`default_nettype none

package qspr_pkg;

    localparam int POS_W      = 32;
    localparam int SPEED_W    = 16;
    localparam int DUTY_W     = 10;
    localparam int LIMIT_W    = 15;
    localparam int DECIM_W    = 8;
    localparam int X_W        = 22;
    localparam int GAIN_SCALE = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SPEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION     = 2'd3;

    localparam logic signed [SPEED_W-1:0] TARGET_SPEED_RST   = 16'sd0;
    localparam logic [DUTY_W-1:0]         PWM_TOP_RST        = 10'd1000;
    localparam logic [LIMIT_W-1:0]        INTEGRAL_LIMIT_RST = 15'd3000;
    localparam logic [DECIM_W-1:0]        DECIMATION_RST     = 8'd10;

    typedef logic signed [2:0] t_edge;

    typedef struct packed {
        logic enc_one_a;
        logic enc_one_b;
        logic enc_two_a;
        logic enc_two_b;
        logic regulate;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]   position_one;
        logic signed [POS_W-1:0]   position_two;
        logic signed [SPEED_W-1:0] measured_speed;
        logic signed [SPEED_W-1:0] effort;
        logic [DUTY_W-1:0]         duty;
        logic                      forward;
    } t_out_item;

    // Count change of one encoder for new pins a, b and previous pins pa, pb.
    function automatic t_edge edge_delta(input logic a, input logic b,
                                         input logic pa, input logic pb);
        t_edge d;
        d = 3'sd0;
        if (a != pa) begin
            d = (a ^ b) ? -3'sd1 : 3'sd1;
        end
        if (b != pb) begin
            d = d + ((a ^ b) ? 3'sd1 : -3'sd1);
        end
        return d;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/qspr_cdiv.sv */
// Signed division by a constant, truncated toward zero, by reciprocal multiply.
// The product is registered when i_en is high; the quotient follows that register.
// Depends on nothing.
`default_nettype none

module qspr_cdiv #(
    parameter int DIVISOR = 5,
    parameter int IN_W    = 19
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IN_W-1:0] i_value,
    output logic signed [IN_W-1:0] o_quot
);

    localparam int SHIFT  = IN_W + $clog2(DIVISOR);
    localparam int MULT_W = SHIFT + 1;
    localparam int PROD_W = IN_W + MULT_W;
    localparam longint unsigned MULT_L = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);

    logic [IN_W-1:0]   w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg;
    logic [IN_W-1:0]   w_q;

    assign w_mag  = i_value[IN_W-1] ? $unsigned(-i_value) : $unsigned(i_value);
    assign w_prod = PROD_W'(w_mag) * PROD_W'(MULT);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod;
            r_neg  <= i_value[IN_W-1];
        end
    end

    assign w_q    = r_prod[SHIFT +: IN_W];
    assign o_quot = r_neg ? -$signed(w_q) : $signed(w_q);

endmodule

`default_nettype wire

/* hw/rtl/quadrature_speed_pi_regulator_unit.sv */
// Top level: x4 quadrature decoding of two encoders and a PI speed regulator.
// Depends on qspr_pkg and qspr_cdiv.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_in_data (t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while o_in_stall is low.
// The pipeline has seven registers: decode, speed window, error sum,
// average divider, integral update, effort divider and the output register.
// Reset is synchronous and active low; it clears the valid flags and restores the
// settings and the regulator state to their reset values.
// A stall on the output fills the pipeline before the input stalls.
`default_nettype none

module quadrature_speed_pi_regulator_unit
    import qspr_pkg::*;
#(
    parameter int WINDOW_LENGTH = 5,
    parameter int COUNT_BITS    = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SUM_W = SPEED_W + $clog2(WINDOW_LENGTH);
    localparam int PAD_W = (COUNT_BITS > POS_W) ? COUNT_BITS : POS_W;
    localparam logic signed [X_W-1:0] X_MAX = X_W'(32767);
    localparam logic signed [X_W-1:0] X_MIN = X_W'(-32768);

    typedef struct packed {
        logic [POS_W-1:0]          pos_one;
        logic [POS_W-1:0]          pos_two;
        logic signed [SPEED_W-1:0] speed;
        logic                      regulate;
    } t_flow;

    logic signed [SPEED_W-1:0] r_target;
    logic [DUTY_W-1:0]         r_pwm_top;
    logic [LIMIT_W-1:0]        r_int_limit;
    logic [DECIM_W-1:0]        r_decimation;

    logic [3:0]                r_prev_pins;
    logic [COUNT_BITS-1:0]     r_count_one;
    logic [COUNT_BITS-1:0]     r_count_two;
    logic [SPEED_W-1:0]        r_win_start;
    logic [DECIM_W-1:0]        r_step;
    logic signed [SPEED_W-1:0] r_speed;
    logic signed [SPEED_W-1:0] r_hist [WINDOW_LENGTH];
    logic signed [SPEED_W-1:0] r_integral;
    logic signed [SPEED_W-1:0] r_last_effort;

    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid, r_s6_valid;
    logic r_out_valid;
    t_flow r_s1, r_s2, r_s3, r_s4, r_s5, r_s6;
    t_flow n_s2;
    logic signed [SUM_W-1:0]   r_s3_sum;
    logic signed [SPEED_W-1:0] r_s5_avg;
    logic signed [SPEED_W-1:0] r_s5_int;
    t_out_item r_out;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6, w_rdy_out;
    logic w_ld1, w_ld2, w_ld3, w_ld4, w_ld5, w_ld6, w_ld_out;

    t_edge                   w_d1, w_d2;
    logic [COUNT_BITS-1:0]   n_count_one, n_count_two;
    logic [PAD_W-1:0]        w_pad_one, w_pad_two;

    logic [DECIM_W-1:0]        w_step_inc;
    logic                      w_measure;
    logic signed [SPEED_W-1:0] w_speed_meas;
    logic signed [SPEED_W-1:0] n_speed;
    logic signed [SPEED_W:0]   w_err_wide;
    logic signed [SPEED_W-1:0] w_err;

    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_avg_q;
    logic signed [SPEED_W-1:0] w_avg;
    logic signed [SPEED_W:0]   w_int_sum;
    logic signed [SPEED_W:0]   w_lim;
    logic signed [SPEED_W:0]   w_nlim;
    logic signed [SPEED_W-1:0] n_integral;

    logic signed [X_W-1:0]     w_avg_x, w_int_x, w_x;
    logic signed [X_W-1:0]     w_eff_q;
    logic signed [SPEED_W-1:0] w_eff_sat;
    logic signed [SPEED_W-1:0] w_eff_sel;
    logic [SPEED_W-1:0]        w_mag;
    logic [DUTY_W-1:0]         w_duty;
    logic                      w_forward;

    // Pipeline flow control.
    assign w_rdy_out = !r_out_valid || !i_out_stall;
    assign w_rdy6    = !r_s6_valid || w_rdy_out;
    assign w_rdy5    = !r_s5_valid || w_rdy6;
    assign w_rdy4    = !r_s4_valid || w_rdy5;
    assign w_rdy3    = !r_s3_valid || w_rdy4;
    assign w_rdy2    = !r_s2_valid || w_rdy3;
    assign w_rdy1    = !r_s1_valid || w_rdy2;

    assign w_ld1    = i_in_valid && w_rdy1;
    assign w_ld2    = r_s1_valid && w_rdy2;
    assign w_ld3    = r_s2_valid && w_rdy3;
    assign w_ld4    = r_s3_valid && w_rdy4;
    assign w_ld5    = r_s4_valid && w_rdy5;
    assign w_ld6    = r_s5_valid && w_rdy6;
    assign w_ld_out = r_s6_valid && w_rdy_out;

    assign o_in_stall  = !w_rdy1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_rdy2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_rdy3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (w_rdy4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (w_rdy5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (w_rdy6) begin
                r_s6_valid <= r_s5_valid;
            end
            if (w_rdy_out) begin
                r_out_valid <= r_s6_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= TARGET_SPEED_RST;
            r_pwm_top    <= PWM_TOP_RST;
            r_int_limit  <= INTEGRAL_LIMIT_RST;
            r_decimation <= DECIMATION_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_SPEED: begin
                    r_target <= i_cfg_data;
                end
                CFG_PWM_TOP: begin
                    r_pwm_top <= i_cfg_data[DUTY_W-1:0];
                end
                CFG_INTEGRAL_LIMIT: begin
                    r_int_limit <= i_cfg_data[LIMIT_W-1:0];
                end
                CFG_DECIMATION: begin
                    r_decimation <= i_cfg_data[DECIM_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Decode stage.
    assign w_d1 = edge_delta(i_in_data.enc_one_a, i_in_data.enc_one_b,
                             r_prev_pins[0], r_prev_pins[1]);
    assign w_d2 = edge_delta(i_in_data.enc_two_a, i_in_data.enc_two_b,
                             r_prev_pins[2], r_prev_pins[3]);
    assign n_count_one = r_count_one + {{(COUNT_BITS-3){w_d1[2]}}, w_d1};
    assign n_count_two = r_count_two + {{(COUNT_BITS-3){w_d2[2]}}, w_d2};
    assign w_pad_one   = PAD_W'(n_count_one);
    assign w_pad_two   = PAD_W'(n_count_two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pins <= '0;
            r_count_one <= '0;
            r_count_two <= '0;
        end else if (w_ld1) begin
            r_prev_pins <= {i_in_data.enc_two_b, i_in_data.enc_two_a,
                            i_in_data.enc_one_b, i_in_data.enc_one_a};
            r_count_one <= n_count_one;
            r_count_two <= n_count_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1) begin
            r_s1.pos_one  <= w_pad_one[POS_W-1:0];
            r_s1.pos_two  <= w_pad_two[POS_W-1:0];
            r_s1.speed    <= '0;
            r_s1.regulate <= i_in_data.regulate;
        end
    end

    // Speed window and error history stage.
    assign w_step_inc   = r_step + 8'd1;
    assign w_measure    = (w_step_inc == r_decimation);
    assign w_speed_meas = r_s1.pos_two[SPEED_W-1:0] - r_win_start;
    assign n_speed      = w_measure ? w_speed_meas : r_speed;
    assign w_err_wide   = (SPEED_W+1)'(r_target) - (SPEED_W+1)'(n_speed);

    always_comb begin
        if (w_err_wide[SPEED_W] != w_err_wide[SPEED_W-1]) begin
            w_err = w_err_wide[SPEED_W] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            w_err = w_err_wide[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_win_start <= '0;
            r_speed     <= '0;
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (w_ld2 && r_s1.regulate) begin
            r_step  <= w_measure ? '0 : w_step_inc;
            r_speed <= n_speed;
            if (w_measure) begin
                r_win_start <= r_s1.pos_two[SPEED_W-1:0];
            end
            for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[WINDOW_LENGTH-1] <= w_err;
        end
    end

    always_comb begin
        n_s2       = r_s1;
        n_s2.speed = r_s1.regulate ? n_speed : r_speed;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld2) begin
            r_s2 <= n_s2;
        end
    end

    // Error sum stage.
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            w_sum = w_sum + SUM_W'(r_hist[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld3) begin
            r_s3     <= r_s2;
            r_s3_sum <= w_sum;
        end
    end

    // Average stage.
    qspr_cdiv #(
        .DIVISOR (WINDOW_LENGTH),
        .IN_W    (SUM_W)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_en    (w_ld4),
        .i_value (r_s3_sum),
        .o_quot  (w_avg_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_ld4) begin
            r_s4 <= r_s3;
        end
    end

    // Integral stage.
    assign w_avg     = w_avg_q[SPEED_W-1:0];
    assign w_int_sum = (SPEED_W+1)'(r_integral) + (SPEED_W+1)'(w_avg);
    assign w_lim     = {2'b00, r_int_limit};
    assign w_nlim    = -w_lim;

    always_comb begin
        if (w_int_sum > w_lim) begin
            n_integral = w_lim[SPEED_W-1:0];
        end else if (w_int_sum < w_nlim) begin
            n_integral = w_nlim[SPEED_W-1:0];
        end else begin
            n_integral = w_int_sum[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
        end else if (w_ld5 && r_s4.regulate) begin
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld5) begin
            r_s5     <= r_s4;
            r_s5_avg <= w_avg;
            r_s5_int <= r_integral;
        end
    end

    // Effort stage: 40 * avg + 9 * integral, then divided by ten.
    assign w_avg_x = X_W'(r_s5_avg);
    assign w_int_x = X_W'(r_s5_int);
    assign w_x     = (w_avg_x <<< 5) + (w_avg_x <<< 3) + (w_int_x <<< 3) + w_int_x;

    qspr_cdiv #(
        .DIVISOR (GAIN_SCALE),
        .IN_W    (X_W)
    ) u_eff_div (
        .i_clk   (i_clk),
        .i_en    (w_ld6),
        .i_value (w_x),
        .o_quot  (w_eff_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_ld6) begin
            r_s6 <= r_s5;
        end
    end

    // Output stage.
    always_comb begin
        if (w_eff_q > X_MAX) begin
            w_eff_sat = 16'sh7FFF;
        end else if (w_eff_q < X_MIN) begin
            w_eff_sat = 16'sh8000;
        end else begin
            w_eff_sat = w_eff_q[SPEED_W-1:0];
        end
    end

    assign w_eff_sel = r_s6.regulate ? w_eff_sat : r_last_effort;
    assign w_mag     = w_eff_sel[SPEED_W-1] ? $unsigned(-w_eff_sel) : $unsigned(w_eff_sel);
    assign w_duty    = (w_mag > SPEED_W'(r_pwm_top)) ? r_pwm_top : w_mag[DUTY_W-1:0];
    assign w_forward = !w_eff_sel[SPEED_W-1] && (w_eff_sel != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_effort <= '0;
        end else if (w_ld_out && r_s6.regulate) begin
            r_last_effort <= w_eff_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_out) begin
            r_out.position_one   <= r_s6.pos_one;
            r_out.position_two   <= r_s6.pos_two;
            r_out.measured_speed <= r_s6.speed;
            r_out.effort         <= w_eff_sel;
            r_out.duty           <= w_duty;
            r_out.forward        <= w_forward;
        end
    end

`ifndef SYNTHESIS
    ap_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid)
        else $error("input stalled while the first stage is empty");

    ap_out_from_s6: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s6_valid))
        else $error("output item appeared without a source item");

    ap_s6_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s6_valid && !w_rdy_out) |=> (r_s6_valid && $stable(r_s6)))
        else $error("blocked item in the last stage was lost or changed");

    ap_forward_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_out_data.forward == (o_out_data.effort > 0)))
        else $error("direction does not match the sign of the effort");
`endif

endmodule

`default_nettype wire
